[rtl/ilb_pkg.sv]
package ilb_pkg;

    localparam logic [2:0] FUNC_READ   = 3'd0;
    localparam logic [2:0] FUNC_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_INSERT = 3'd2;
    localparam logic [2:0] FUNC_REMOVE = 3'd3;
    localparam logic [2:0] FUNC_APPEND = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [4:0]         position;
        logic signed [31:0] word_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] word_out;
        logic [1:0]         status;
        logic [4:0]         count;
    } t_out_item;

endpackage

[rtl/indexed_list_buffer.sv]
// Ordered list of up to DEPTH words held in one synchronous memory.
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one operation per
// transaction: read, write, insert or remove at a position, append, or clear.
// Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly one
// result per operation: the word read, a status and the entry count after it.
// One operation is in flight at a time; o_in_stall is high until its result
// has been placed in the output register.
// Read, write, append, clear and failed operations move no entries; insert at
// a position p below the entry count moves each entry from the top down to p up
// by one and then writes the new word at p; remove at a position p below the
// top entry moves each entry above p down by one. Insert and remove move one
// entry per cycle through the memory, which has one read and one write port
// and a registered read.
// A new operation is accepted while the previous result still waits in the
// output register; when the receiver stalls, the finished result holds in the
// block and o_in_stall stays high until the output register frees.
// After reset the list is empty; the memory content is not cleared and needs
// no clearing pass.
module indexed_list_buffer
    import ilb_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_REM,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_used, n_used;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_pos, n_pos;
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic [1:0]             r_status, n_status;
    logic                   r_rd_ok, n_rd_ok;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic [WORD_BITS-1:0]   r_mem [DEPTH];
    logic [WORD_BITS-1:0]   r_rdata;

    logic                   w_we, w_re;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [WORD_BITS-1:0]   w_wdata;

    logic                   w_in_accept;
    logic [PW-1:0]          w_pos_ext, w_used_ext;
    logic [AW-1:0]          w_pos_a;
    logic [WORD_BITS-1:0]   w_word;
    logic                   w_full;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_pos_ext   = PW'(i_in_item.position);
    assign w_used_ext  = PW'(r_used);
    assign w_pos_a     = AW'(i_in_item.position);
    assign w_word      = WORD_BITS'($unsigned(i_in_item.word_in));
    assign w_full      = (r_used == CW'(DEPTH));

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_word      = r_word;
        n_status    = r_status;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_rdata;
        w_re        = 1'b0;
        w_raddr     = r_idx;

        // drop the output transaction once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_status = STATUS_OK;
                    n_rd_ok  = 1'b0;
                    n_state  = S_DONE;
                    case (i_in_item.func)
                        FUNC_READ: begin
                            if (w_pos_ext >= w_used_ext) begin
                                n_status = STATUS_RANGE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_pos_a;
                                n_rd_ok = 1'b1;
                            end
                        end
                        FUNC_WRITE: begin
                            if (w_pos_ext >= w_used_ext) begin
                                n_status = STATUS_RANGE;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_pos_a;
                                w_wdata = w_word;
                            end
                        end
                        FUNC_INSERT: begin
                            if (w_pos_ext > w_used_ext) begin
                                n_status = STATUS_RANGE;
                            end else if (w_full) begin
                                n_status = STATUS_FULL;
                            end else if (w_pos_ext == w_used_ext) begin
                                w_we    = 1'b1;
                                w_waddr = AW'(r_used);
                                w_wdata = w_word;
                                n_used  = r_used + CW'(1);
                            end else begin
                                // start moving entries up from the top one
                                w_re    = 1'b1;
                                w_raddr = AW'(r_used - CW'(1));
                                n_idx   = AW'(r_used - CW'(1));
                                n_pos   = w_pos_a;
                                n_word  = w_word;
                                n_state = S_INS;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (w_pos_ext >= w_used_ext) begin
                                n_status = STATUS_RANGE;
                            end else if (w_pos_ext == w_used_ext - PW'(1)) begin
                                n_used = r_used - CW'(1);
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(w_pos_ext + PW'(1));
                                n_idx   = AW'(w_pos_ext + PW'(1));
                                n_state = S_REM;
                            end
                        end
                        FUNC_APPEND: begin
                            if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = AW'(r_used);
                                w_wdata = w_word;
                                n_used  = r_used + CW'(1);
                            end
                        end
                        FUNC_CLEAR: begin
                            n_used = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_idx + AW'(1);
                w_wdata = r_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = r_word;
                n_used  = r_used + CW'(1);
                n_state = S_DONE;
            end
            S_REM: begin
                w_we    = 1'b1;
                w_waddr = r_idx - AW'(1);
                w_wdata = r_rdata;
                if (PW'(r_idx) == w_used_ext - PW'(1)) begin
                    n_used  = r_used - CW'(1);
                    n_state = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out.word_out  = r_rd_ok ? 32'(r_rdata) : '0;
                    n_out.status    = r_status;
                    n_out.count     = 5'(r_used);
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_status <= n_status;
        r_rd_ok  <= n_rd_ok;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("second transaction accepted while one is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == STATUS_FULL) |-> o_out_item.count == 5'(DEPTH))
        else $error("full status with list not full");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != STATUS_OK) |-> o_out_item.word_out == '0)
        else $error("failed operation returned data");

endmodule

[tb/indexed_list_buffer_tb.sv]
`timescale 1ns / 100ps

module indexed_list_buffer_tb;
    import ilb_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int N_RANDOM     = 1300;
    localparam int MAX_IDLE     = 11;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 400000;

    // func codes the block does not define; they must leave the list alone
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIXED} t_trend;

    class list_tracker;
        logic [31:0] words [LIST_DEPTH];
        logic [4:0]  n_used;
        t_out_item   pending [$];
        int          n_errors;

        function new();
            n_used   = '0;
            n_errors = 0;
        endfunction

        // Apply one accepted transaction to the shadow list and queue its result.
        function void take_op(t_in_item op);
            t_out_item res;
            int        k;
            res        = '0;
            res.status = STATUS_OK;
            case (op.func)
                FUNC_READ: begin
                    if (op.position >= n_used) begin
                        res.status = STATUS_RANGE;
                    end else begin
                        res.word_out = words[4'(op.position)];
                    end
                end
                FUNC_WRITE: begin
                    if (op.position >= n_used) begin
                        res.status = STATUS_RANGE;
                    end else begin
                        words[4'(op.position)] = op.word_in;
                    end
                end
                FUNC_INSERT: begin
                    // range test wins over full
                    if (op.position > n_used) begin
                        res.status = STATUS_RANGE;
                    end else if (n_used == 5'(LIST_DEPTH)) begin
                        res.status = STATUS_FULL;
                    end else begin
                        for (k = int'(n_used); k > int'(op.position); k--) begin
                            words[4'(k)] = words[4'(k - 1)];
                        end
                        words[4'(op.position)] = op.word_in;
                        n_used++;
                    end
                end
                FUNC_REMOVE: begin
                    if (op.position >= n_used) begin
                        res.status = STATUS_RANGE;
                    end else begin
                        for (k = int'(op.position); k + 1 < int'(n_used); k++) begin
                            words[4'(k)] = words[4'(k + 1)];
                        end
                        n_used--;
                    end
                end
                FUNC_APPEND: begin
                    if (n_used == 5'(LIST_DEPTH)) begin
                        res.status = STATUS_FULL;
                    end else begin
                        words[4'(n_used)] = op.word_in;
                        n_used++;
                    end
                end
                FUNC_CLEAR: begin
                    n_used = '0;
                end
                default: begin
                end
            endcase
            res.count = n_used;
            pending.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
            n_errors++;
        endtask

        task match_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("unexpected result", got.word_out, '0);
            end else begin
                want = pending.pop_front();
                if (got.word_out !== want.word_out) begin
                    report("word_out", got.word_out, want.word_out);
                end
                if (got.status !== want.status) begin
                    report("status", 32'(got.status), 32'(want.status));
                end
                if (got.count !== want.count) begin
                    report("count", 32'(got.count), 32'(want.count));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    list_tracker tracker;
    int          tx_idle_max;

    indexed_list_buffer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one transaction after a random gap and hold it until accepted.
    task automatic send_op(logic [2:0] func, logic [4:0] position, logic [31:0] word);
        int       gap;
        t_in_item op;
        gap         = $urandom_range(0, tx_idle_max);
        op.func     = func;
        op.position = position;
        op.word_in  = word;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        tracker.take_op(op);
    endtask

    initial begin
        int          n;
        int          r;
        int          cnt;
        int          add_pct;
        int          del_pct;
        t_trend      trend;
        logic [2:0]  func;
        logic [4:0]  pos;
        logic [31:0] word;
        tracker     = new();
        tx_idle_max = MAX_IDLE;
        trend       = TREND_GROW;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: clear, then every indexed access out of range
        send_op(FUNC_CLEAR, 5'd0, 32'h0);
        send_op(FUNC_READ, 5'd0, 32'h0);
        send_op(FUNC_WRITE, 5'd0, 32'h0000_1234);
        send_op(FUNC_REMOVE, 5'd0, 32'h0);
        send_op(FUNC_INSERT, 5'd1, 32'h0000_5555);
        // build a short list from the extremes of the word
        send_op(FUNC_INSERT, 5'd0, 32'h7fff_ffff);
        send_op(FUNC_APPEND, 5'd31, 32'h8000_0000);
        send_op(FUNC_APPEND, 5'd0, 32'hffff_ffff);
        send_op(FUNC_APPEND, 5'd0, 32'h0);
        send_op(FUNC_INSERT, 5'd2, 32'ha5a5_5a5a);
        send_op(FUNC_INSERT, 5'd5, 32'h5a5a_a5a5);
        send_op(FUNC_INSERT, 5'd7, 32'h0);
        send_op(FUNC_READ, 5'd0, 32'h0);
        send_op(FUNC_READ, 5'd2, 32'h0);
        send_op(FUNC_READ, 5'd5, 32'h0);
        send_op(FUNC_READ, 5'd6, 32'h0);
        send_op(FUNC_READ, 5'd31, 32'hffff_ffff);
        send_op(FUNC_WRITE, 5'd1, 32'hdead_beef);
        send_op(FUNC_WRITE, 5'd6, 32'h1);
        send_op(FUNC_REMOVE, 5'd0, 32'h0);
        send_op(FUNC_REMOVE, 5'd4, 32'h0);
        send_op(FUNC_REMOVE, 5'd4, 32'h0);
        send_op(FUNC_SPARE_LO, 5'd0, 32'h0);
        send_op(FUNC_SPARE_HI, 5'd31, 32'hffff_ffff);
        send_op(FUNC_CLEAR, 5'd0, 32'h0);

        // phases that fill, drain or churn the list; the first one fills it
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) begin
                if (n != 0) begin
                    trend = t_trend'($urandom_range(0, 2));
                end
                tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            end
            case (trend)
                TREND_GROW: begin
                    add_pct = 60;
                    del_pct = 8;
                end
                TREND_SHRINK: begin
                    add_pct = 15;
                    del_pct = 50;
                end
                default: begin
                    add_pct = 35;
                    del_pct = 30;
                end
            endcase
            r   = $urandom_range(0, 99);
            cnt = int'(tracker.n_used);
            if (r < 4) begin
                func = 3'($urandom_range(FUNC_READ, FUNC_SPARE_HI));
            end else if (r < 4 + add_pct) begin
                func = ($urandom_range(0, 1) != 0) ? FUNC_APPEND : FUNC_INSERT;
            end else if (r < 4 + add_pct + del_pct) begin
                func = FUNC_REMOVE;
            end else begin
                func = ($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_WRITE;
            end
            // mostly valid positions, one step past the end included
            if ($urandom_range(0, 9) == 0) begin
                pos = 5'($urandom_range(0, 31));
            end else begin
                pos = 5'($urandom_range(0, cnt));
            end
            case ($urandom_range(0, 7))
                0: word = 32'h8000_0000;
                1: word = 32'h7fff_ffff;
                2: word = ($urandom_range(0, 1) != 0) ? '0 : '1;
                default: word = $urandom;
            endcase
            send_op(func, pos, word);
        end
        i_in_valid <= 1'b0;

        while (tracker.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: random stalls, bursts without stalls, and two long hold-offs
    // that back the block up into its input.
    initial begin
        int rx_idle_max;
        int n_results;
        int stall_len;
        i_out_stall <= 1'b0;
        rx_idle_max = MAX_IDLE;
        n_results   = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_results % 64 == 0) begin
                rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            end
            if (n_results == 300 || n_results == 900) begin
                stall_len = HOLD_CYCLES;
            end else begin
                stall_len = $urandom_range(0, rx_idle_max);
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
            tracker.match_result(o_out_item);
            n_results++;
        end
    end

    initial begin
        int n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, n_cycles);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/ilb_pkg.sv
rtl/indexed_list_buffer.sv
tb/indexed_list_buffer_tb.sv
